// ----- rtl/core/tbr_pkg.sv -----
// Shared constants and register index codes for the triangle bounding-box rasterizer.
package tbr_pkg;

  localparam int COORD_BITS_DEF  = 12;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int ORIGIN_W   = 12;
  localparam int PITCH_W    = 13;
  localparam int LIMIT_W    = 12;
  localparam int INDEX_W    = 26;
  localparam int COLOR_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [ORIGIN_W-1:0] ORIGIN_X_RST = 12'd0;
  localparam logic [ORIGIN_W-1:0] ORIGIN_Y_RST = 12'd0;
  localparam logic [PITCH_W-1:0]  PITCH_RST    = 13'd640;
  localparam logic [LIMIT_W-1:0]  LIMIT_X_RST  = 12'd640;
  localparam logic [LIMIT_W-1:0]  LIMIT_Y_RST  = 12'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_ROW_PITCH = 3'd2,
    REG_LIMIT_X   = 3'd3,
    REG_LIMIT_Y   = 3'd4
  } cfg_reg_t;

endpackage

// ----- rtl/core/tbr_queue.sv -----
// Short first-in first-out queue between the front and the back of the rasterizer.
module tbr_queue import tbr_pkg::*; #(
  parameter int WIDTH = 1 + 10 * COORD_BITS_DEF + COLOR_W,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_pop,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign wr_ready = (count_r != CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_push  = wr_valid && wr_ready;
  assign do_pop   = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/core/tbr_front.sv -----
// Front end: takes input transactions, classifies them and forms the bounding box.
module tbr_front import tbr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ITEM_W     = 1 + 10 * COORD_BITS + COLOR_W
) (
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_mode,
  input  logic signed [COORD_BITS-1:0] in_ax,
  input  logic signed [COORD_BITS-1:0] in_ay,
  input  logic signed [COORD_BITS-1:0] in_bx,
  input  logic signed [COORD_BITS-1:0] in_by,
  input  logic signed [COORD_BITS-1:0] in_cx,
  input  logic signed [COORD_BITS-1:0] in_cy,
  input  logic [COLOR_W-1:0]           in_fill_color,
  output logic                         push_valid,
  input  logic                         push_ready,
  output logic [ITEM_W-1:0]            push_data
);

  localparam int CW = COORD_BITS;

  typedef struct packed {
    logic                 is_tick;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] xmin;
    logic signed [CW-1:0] ymin;
    logic signed [CW-1:0] xmax;
    logic signed [CW-1:0] ymax;
    logic [COLOR_W-1:0]   color;
  } item_t;

  function automatic logic signed [CW-1:0] min3(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b,
                                                input logic signed [CW-1:0] c);
    logic signed [CW-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [CW-1:0] max3(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b,
                                                input logic signed [CW-1:0] c);
    logic signed [CW-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  item_t itm;

  always_comb begin
    itm.is_tick = in_mode;
    itm.ax      = in_ax;
    itm.ay      = in_ay;
    itm.bx      = in_bx;
    itm.by      = in_by;
    itm.cx      = in_cx;
    itm.cy      = in_cy;
    itm.xmin    = min3(in_ax, in_bx, in_cx);
    itm.ymin    = min3(in_ay, in_by, in_cy);
    itm.xmax    = max3(in_ax, in_bx, in_cx);
    itm.ymax    = max3(in_ay, in_by, in_cy);
    itm.color   = in_fill_color;
  end

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign push_data  = ITEM_W'(itm);

endmodule

// ----- rtl/core/tbr_back.sv -----
// Back end: scan sequencer, edge tests, address generation and the result register.
module tbr_back import tbr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ITEM_W     = 1 + 10 * COORD_BITS + COLOR_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  logic [ITEM_W-1:0]     q_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_write_enable,
  output logic [INDEX_W-1:0]    out_pixel_index,
  output logic [COLOR_W-1:0]    out_pixel_word,
  output logic                  out_scan_done
);

  localparam int CW    = COORD_BITS;
  localparam int DW    = CW + 1;
  localparam int PW    = 2 * DW;
  localparam int EW    = PW + 1;
  localparam int SUM_W = ((CW > ORIGIN_W) ? CW : ORIGIN_W) + 1;
  localparam int IW    = SUM_W + PITCH_W;

  typedef struct packed {
    logic                 is_tick;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] xmin;
    logic signed [CW-1:0] ymin;
    logic signed [CW-1:0] xmax;
    logic signed [CW-1:0] ymax;
    logic [COLOR_W-1:0]   color;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  function automatic logic same_side(input logic signed [EW-1:0] p,
                                     input logic signed [EW-1:0] q);
    return (p == '0) || (q == '0) || (p[EW-1] == q[EW-1]);
  endfunction

  state_t state_r;
  state_t state_nxt;

  logic [ORIGIN_W-1:0] ox_r;
  logic [ORIGIN_W-1:0] oy_r;
  logic [PITCH_W-1:0]  pitch_r;
  logic [LIMIT_W-1:0]  lx_r;
  logic [LIMIT_W-1:0]  ly_r;

  logic signed [CW-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic signed [CW-1:0] xmin_r, ymin_r, xmax_r, ymax_r;
  logic [COLOR_W-1:0]   color_r;
  logic [CW-1:0]        w_r, h_r;
  logic signed [DW-1:0] dcy_ay_r, dcx_ax_r, day_by_r, dax_bx_r, dcy_by_r, dcx_bx_r;
  logic [CW-1:0]        dx_r, dy_r;
  logic                 active_r;
  logic                 eval_r;
  logic signed [DW-1:0] x_r, y_r, u_r, v_r;
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic [INDEX_W-1:0]   idx_prod_r;
  logic [SUM_W-1:0]     colx_r;

  logic                 out_valid_r;
  logic                 out_we_r;
  logic [INDEX_W-1:0]   out_index_r;
  logic [COLOR_W-1:0]   out_word_r;
  logic                 out_done_r;

  item_t                itm;
  logic                 pop_go;
  logic                 emit_go;
  logic signed [DW-1:0] px, py;
  logic [CW-1:0]        w_nxt, h_nxt;
  logic                 load_ok;
  logic [CW-1:0]        dx1, dy1;
  logic                 col1_ok, row1_ok, col0_ok, row0_ok;
  logic [SUM_W-1:0]     rowy;
  logic [IW-1:0]        idx_full;
  logic signed [EW-1:0] e0, e1, e2;
  logic                 cov;

  assign itm       = item_t'(q_data);
  assign pop_go    = (state_r == ST_IDLE) && q_valid;
  assign q_pop     = pop_go;
  assign emit_go   = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign cfg_ready = 1'b1;

  assign px = DW'(xmin_r) + DW'(dx_r);
  assign py = DW'(ymin_r) + DW'(dy_r);

  assign w_nxt   = CW'(xmax_r - xmin_r);
  assign h_nxt   = CW'(ymax_r - ymin_r);
  assign load_ok = (w_nxt != '0) && (h_nxt != '0) && (ox_r < lx_r) && (oy_r < ly_r);

  assign dx1     = dx_r + CW'(1);
  assign dy1     = dy_r + CW'(1);
  assign col1_ok = (dx1 < w_r) && ((SUM_W'(ox_r) + SUM_W'(dx1)) < SUM_W'(lx_r));
  assign row1_ok = (dy1 < h_r) && ((SUM_W'(oy_r) + SUM_W'(dy1)) < SUM_W'(ly_r));
  assign col0_ok = (w_r != '0) && (ox_r < lx_r);
  assign row0_ok = (h_r != '0) && (oy_r < ly_r);

  assign rowy     = SUM_W'(oy_r) + SUM_W'(dy_r);
  assign idx_full = IW'(rowy) * IW'(pitch_r);

  assign e0  = EW'(p0_r) - EW'(p1_r);
  assign e1  = EW'(p2_r) - EW'(p3_r);
  assign e2  = EW'(p4_r) - EW'(p5_r);
  assign cov = eval_r && same_side(e0, e1) && same_side(e1, e2) && same_side(e0, e2);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (!itm.is_tick) begin
            state_nxt = ST_LOAD;
          end else if (active_r) begin
            state_nxt = ST_MUL;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_LOAD: state_nxt = ST_EMIT;
      ST_MUL:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= 1'b0;
      eval_r      <= 1'b0;
      dx_r        <= '0;
      dy_r        <= '0;
      out_valid_r <= 1'b0;
      ox_r        <= ORIGIN_X_RST;
      oy_r        <= ORIGIN_Y_RST;
      pitch_r     <= PITCH_RST;
      lx_r        <= LIMIT_X_RST;
      ly_r        <= LIMIT_Y_RST;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_ORIGIN_X:  ox_r    <= cfg_data[ORIGIN_W-1:0];
          REG_ORIGIN_Y:  oy_r    <= cfg_data[ORIGIN_W-1:0];
          REG_ROW_PITCH: pitch_r <= cfg_data[PITCH_W-1:0];
          REG_LIMIT_X:   lx_r    <= cfg_data[LIMIT_W-1:0];
          REG_LIMIT_Y:   ly_r    <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end

      if (pop_go) begin
        if (!itm.is_tick) begin
          eval_r <= 1'b0;
          dx_r   <= '0;
          dy_r   <= '0;
        end else begin
          eval_r <= active_r;
        end
      end

      if (state_r == ST_LOAD) begin
        active_r <= load_ok;
      end

      if (state_r == ST_MUL) begin
        if (col1_ok) begin
          dx_r <= dx1;
        end else begin
          dx_r <= '0;
          if (!row1_ok || !col0_ok || !row0_ok) begin
            active_r <= 1'b0;
            dy_r     <= '0;
          end else begin
            dy_r <= dy1;
          end
        end
      end

      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_go) begin
      if (!itm.is_tick) begin
        ax_r    <= itm.ax;
        ay_r    <= itm.ay;
        bx_r    <= itm.bx;
        by_r    <= itm.by;
        cx_r    <= itm.cx;
        cy_r    <= itm.cy;
        xmin_r  <= itm.xmin;
        ymin_r  <= itm.ymin;
        xmax_r  <= itm.xmax;
        ymax_r  <= itm.ymax;
        color_r <= itm.color;
      end else begin
        x_r <= px - DW'(ax_r);
        y_r <= py - DW'(ay_r);
        u_r <= DW'(cx_r) - px;
        v_r <= DW'(cy_r) - py;
      end
    end

    if (state_r == ST_LOAD) begin
      w_r      <= w_nxt;
      h_r      <= h_nxt;
      dcy_ay_r <= DW'(cy_r) - DW'(ay_r);
      dcx_ax_r <= DW'(cx_r) - DW'(ax_r);
      day_by_r <= DW'(ay_r) - DW'(by_r);
      dax_bx_r <= DW'(ax_r) - DW'(bx_r);
      dcy_by_r <= DW'(cy_r) - DW'(by_r);
      dcx_bx_r <= DW'(cx_r) - DW'(bx_r);
    end

    if (state_r == ST_MUL) begin
      p0_r       <= PW'(x_r) * PW'(dcy_ay_r);
      p1_r       <= PW'(dcx_ax_r) * PW'(y_r);
      p2_r       <= PW'(x_r) * PW'(day_by_r);
      p3_r       <= PW'(dax_bx_r) * PW'(y_r);
      p4_r       <= PW'(u_r) * PW'(dcy_by_r);
      p5_r       <= PW'(dcx_bx_r) * PW'(v_r);
      idx_prod_r <= idx_full[INDEX_W-1:0];
      colx_r     <= SUM_W'(ox_r) + SUM_W'(dx_r);
    end

    if (emit_go) begin
      out_we_r    <= cov;
      out_index_r <= cov ? (idx_prod_r + INDEX_W'(colx_r)) : '0;
      out_word_r  <= cov ? color_r : '0;
      out_done_r  <= !active_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_enable = out_we_r;
  assign out_pixel_index  = out_index_r;
  assign out_pixel_word   = out_word_r;
  assign out_scan_done    = out_done_r;

  a_dx_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (dx_r < w_r))
    else $error("Active scan column lies outside the bounding box.");

  a_dy_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (dy_r < h_r))
    else $error("Active scan row lies outside the bounding box.");

  a_emit_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("Result register loaded outside the emit state.");

endmodule

// ----- rtl/core/triangle_bbox_rasterizer_core.sv -----
// Top level of the triangle bounding-box rasterizer: front end, queue and back end.
//
// Usage. Input transactions carry a mode bit: mode 0 loads three vertices and a fill
// color and starts a scan over the half-open bounding box, replacing any scan in
// progress; mode 1 is a tick that tests the next pixel of the scan, row by row.
// Every input transaction yields exactly one result transaction, in order. A covered
// pixel gives write_enable with the pixel index and color; scan_done reports that the
// scan has ended or that no scan is active.
// The configuration channel writes origin, row pitch and limits; it is always ready
// and should be written only while the block is idle.
// The back end sequencer pops an item, passes a load or an active tick through its
// load or multiply stage and then emits the result; an idle tick goes from pop
// straight to emit. It pops no new item until the last result has entered the result
// register, and emit waits while a stalled receiver still holds the earlier result.
// While a result waits on a stalled receiver, the front end and a two-entry queue
// accept input until the queue is full; the back end holds its result until taken.
// Reset (synchronous, active low) empties the queue, stops any scan and restores the
// configuration registers to their reset values.
module triangle_bbox_rasterizer_core import tbr_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_mode,
  input  logic signed [COORD_BITS-1:0] in_ax,
  input  logic signed [COORD_BITS-1:0] in_ay,
  input  logic signed [COORD_BITS-1:0] in_bx,
  input  logic signed [COORD_BITS-1:0] in_by,
  input  logic signed [COORD_BITS-1:0] in_cx,
  input  logic signed [COORD_BITS-1:0] in_cy,
  input  logic [COLOR_W-1:0]           in_fill_color,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_write_enable,
  output logic [INDEX_W-1:0]           out_pixel_index,
  output logic [COLOR_W-1:0]           out_pixel_word,
  output logic                         out_scan_done,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int ITEM_W = 1 + 10 * COORD_BITS + COLOR_W;

  logic              push_valid;
  logic              push_ready;
  logic [ITEM_W-1:0] push_data;
  logic              q_valid;
  logic              q_pop;
  logic [ITEM_W-1:0] q_data;

  tbr_front #(
    .COORD_BITS (COORD_BITS),
    .ITEM_W     (ITEM_W)
  ) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_ax         (in_ax),
    .in_ay         (in_ay),
    .in_bx         (in_bx),
    .in_by         (in_by),
    .in_cx         (in_cx),
    .in_cy         (in_cy),
    .in_fill_color (in_fill_color),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data)
  );

  tbr_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_data),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_data  (q_data)
  );

  tbr_back #(
    .COORD_BITS (COORD_BITS),
    .ITEM_W     (ITEM_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_data           (q_data),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_write_enable (out_write_enable),
    .out_pixel_index  (out_pixel_index),
    .out_pixel_word   (out_pixel_word),
    .out_scan_done    (out_scan_done)
  );

endmodule

// ----- sim/triangle_bbox_rasterizer_core_tb.sv -----
// Self-checking testbench for the triangle bounding-box rasterizer core.
module triangle_bbox_rasterizer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tbr_pkg::*;

  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 250;
  localparam int LONG_HOLD    = 80;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 40;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef logic signed [COORD_BITS_DEF-1:0] coord_t;

  typedef struct packed {
    logic               write_enable;
    logic [INDEX_W-1:0] pixel_index;
    logic [COLOR_W-1:0] pixel_word;
    logic               scan_done;
  } pixel_result_t;

  class pixel_tracker;
    bit [ORIGIN_W-1:0] org_x = ORIGIN_X_RST;
    bit [ORIGIN_W-1:0] org_y = ORIGIN_Y_RST;
    bit [PITCH_W-1:0]  pitch = PITCH_RST;
    bit [LIMIT_W-1:0]  lim_x = LIMIT_X_RST;
    bit [LIMIT_W-1:0]  lim_y = LIMIT_Y_RST;
    int vx[3];
    int vy[3];
    bit [COLOR_W-1:0] color;
    int xmin, ymin, xmax, ymax;
    int dx, dy;
    bit active;
    pixel_result_t expected_pixels[$];
    int failures;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ORIGIN_X:  org_x = data[ORIGIN_W-1:0];
        REG_ORIGIN_Y:  org_y = data[ORIGIN_W-1:0];
        REG_ROW_PITCH: pitch = data[PITCH_W-1:0];
        REG_LIMIT_X:   lim_x = data[LIMIT_W-1:0];
        REG_LIMIT_Y:   lim_y = data[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function int min3(int a, int b, int c);
      int m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
    endfunction

    function int max3(int a, int b, int c);
      int m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
    endfunction

    function bit col_ok(int d);
      return (xmax > xmin) && (d < xmax - xmin) && (int'(org_x) + d < int'(lim_x));
    endfunction

    function bit row_ok(int d);
      return (ymax > ymin) && (d < ymax - ymin) && (int'(org_y) + d < int'(lim_y));
    endfunction

    function bit same_side(longint p, longint q);
      return (p == 0) || (q == 0) || ((p < 0) == (q < 0));
    endfunction

    function bit edges_cover(longint px, longint py);
      longint ax, ay, bx, by, cx, cy, x, y, e0, e1, e2;
      ax = vx[0]; ay = vy[0];
      bx = vx[1]; by = vy[1];
      cx = vx[2]; cy = vy[2];
      x = px - ax;
      y = py - ay;
      e0 = x * (cy - ay) - (cx - ax) * y;
      e1 = x * (ay - by) - (ax - bx) * y;
      e2 = (cx - ax - x) * (cy - by) - (cx - bx) * (cy - ay - y);
      return same_side(e0, e1) && same_side(e1, e2) && same_side(e0, e2);
    endfunction

    function void rasterize_item(bit mode, coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                 coord_t cx, coord_t cy, logic [COLOR_W-1:0] fill);
      pixel_result_t r;
      longint addr;
      r = '0;
      if (!mode) begin
        vx[0] = ax; vy[0] = ay;
        vx[1] = bx; vy[1] = by;
        vx[2] = cx; vy[2] = cy;
        color = fill;
        xmin = min3(vx[0], vx[1], vx[2]);
        ymin = min3(vy[0], vy[1], vy[2]);
        xmax = max3(vx[0], vx[1], vx[2]);
        ymax = max3(vy[0], vy[1], vy[2]);
        dx = 0;
        dy = 0;
        active = row_ok(0) && col_ok(0);
      end else if (active) begin
        if (edges_cover(xmin + dx, ymin + dy)) begin
          addr = (longint'(org_x) + dx) + (longint'(org_y) + dy) * longint'(pitch);
          r.write_enable = 1'b1;
          r.pixel_index  = addr[INDEX_W-1:0];
          r.pixel_word   = color;
        end
        dx++;
        if (!col_ok(dx)) begin
          dx = 0;
          dy++;
          if (!row_ok(dy) || !col_ok(0)) begin
            active = 1'b0;
            dy = 0;
          end
        end
      end
      r.scan_done = !active;
      expected_pixels.push_back(r);
    endfunction

    function void mismatch(string field, logic [COLOR_W-1:0] want, logic [COLOR_W-1:0] got);
      if (failures < MAX_REPORTS)
        $error("%s: expected %0h, got %0h", field, want, got);
      failures++;
    endfunction

    function void compare_pixel(pixel_result_t got);
      pixel_result_t want;
      if (expected_pixels.size() == 0) begin
        if (failures < MAX_REPORTS)
          $error("result transaction with no item outstanding: index %0h word %0h",
                 got.pixel_index, got.pixel_word);
        failures++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.write_enable !== want.write_enable)
        mismatch("write_enable", want.write_enable, got.write_enable);
      if (got.pixel_index !== want.pixel_index)
        mismatch("pixel_index", want.pixel_index, got.pixel_index);
      if (got.pixel_word !== want.pixel_word)
        mismatch("pixel_word", want.pixel_word, got.pixel_word);
      if (got.scan_done !== want.scan_done)
        mismatch("scan_done", want.scan_done, got.scan_done);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_mode;
  coord_t in_ax, in_ay, in_bx, in_by, in_cx, in_cy;
  logic [COLOR_W-1:0] in_fill_color;
  logic out_valid;
  logic out_ready;
  logic out_write_enable;
  logic [INDEX_W-1:0] out_pixel_index;
  logic [COLOR_W-1:0] out_pixel_word;
  logic out_scan_done;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pixel_tracker tracker;
  int items_sent;
  int cycle_count;
  bit quiet;
  bit long_hold_req;

  triangle_bbox_rasterizer_core dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready)
        tracker.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready)
        tracker.rasterize_item(in_mode, in_ax, in_ay, in_bx, in_by, in_cx, in_cy,
                               in_fill_color);
      if (out_valid && out_ready)
        tracker.compare_pixel({out_write_enable, out_pixel_index, out_pixel_word,
                               out_scan_done});
    end
  end

  initial begin
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_req = 1'b0;
        out_ready = 1'b1;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic drive_item(bit mode, coord_t ax, coord_t ay, coord_t bx, coord_t by,
                            coord_t cx, coord_t cy, logic [COLOR_W-1:0] fill);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid      = 1'b1;
    in_mode       = mode;
    in_ax         = ax;
    in_ay         = ay;
    in_bx         = bx;
    in_by         = by;
    in_cx         = cx;
    in_cy         = cy;
    in_fill_color = fill;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_tick();
    drive_item(1'b1, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
               coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), $urandom);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (tracker.expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic program_regs(int ox, int oy, int pt, int lx, int ly);
    write_reg(REG_ORIGIN_X, {1'($urandom), ORIGIN_W'(ox)});
    write_reg(REG_ORIGIN_Y, {1'($urandom), ORIGIN_W'(oy)});
    write_reg(REG_ROW_PITCH, PITCH_W'(pt));
    write_reg(REG_LIMIT_X, {1'($urandom), LIMIT_W'(lx)});
    write_reg(REG_LIMIT_Y, {1'($urandom), LIMIT_W'(ly)});
  endtask

  task automatic program_setting(int phase);
    int ox, oy, lx, ly;
    case (phase)
      1: program_regs(0, 0, 1, 4095, 4095);
      2: begin
        program_regs(4095, 4095, 8191, 0, 0);
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
      end
      3: program_regs(4000, 4000, 4096, 4095, 4095);
      4: program_regs(10, 20, 0, 13, 22);
      default: begin
        ox = $urandom_range(0, 4095);
        oy = $urandom_range(0, 4095);
        lx = ox + $urandom_range(0, 4095 - ox);
        ly = oy + $urandom_range(0, 4095 - oy);
        if ($urandom_range(0, 3) == 0) lx = (ox + 3 > 4095) ? 4095 : ox + 3;
        if ($urandom_range(0, 3) == 0) ly = (oy + 2 > 4095) ? 4095 : oy + 2;
        program_regs(ox, oy, $urandom_range(0, 8191), lx, ly);
      end
    endcase
  endtask

  task automatic send_random_triangle();
    int span_x, span_y, base_x, base_y, lo_x, hi_x, lo_y, hi_y, area, ticks;
    coord_t v[6];
    span_x = ($urandom_range(0, 15) == 0) ? $urandom_range(16, 4095) : $urandom_range(0, 6);
    span_y = ($urandom_range(0, 15) == 0) ? $urandom_range(16, 4095) : $urandom_range(0, 6);
    base_x = $urandom_range(0, 4095 - span_x);
    base_y = $urandom_range(0, 4095 - span_y);
    base_x = base_x - 2048;
    base_y = base_y - 2048;
    for (int i = 0; i < 3; i++) begin
      v[2*i]   = coord_t'(base_x + $urandom_range(0, span_x));
      v[2*i+1] = coord_t'(base_y + $urandom_range(0, span_y));
    end
    lo_x = v[0]; hi_x = v[0]; lo_y = v[1]; hi_y = v[1];
    for (int i = 1; i < 3; i++) begin
      if (v[2*i] < lo_x) lo_x = v[2*i];
      if (v[2*i] > hi_x) hi_x = v[2*i];
      if (v[2*i+1] < lo_y) lo_y = v[2*i+1];
      if (v[2*i+1] > hi_y) hi_y = v[2*i+1];
    end
    area = (hi_x - lo_x) * (hi_y - lo_y);
    if (area > 64)
      ticks = $urandom_range(0, 24);
    else if ($urandom_range(0, 7) == 0)
      ticks = $urandom_range(0, area);
    else
      ticks = area + $urandom_range(0, 2);
    drive_item(1'b0, v[0], v[1], v[2], v[3], v[4], v[5], $urandom);
    repeat (ticks) send_tick();
  endtask

  initial begin
    tracker       = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_mode       = 1'b0;
    in_ax         = '0;
    in_ay         = '0;
    in_bx         = '0;
    in_by         = '0;
    in_cx         = '0;
    in_cy         = '0;
    in_fill_color = '0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_ORIGIN_X;
    cfg_data      = '0;
    quiet         = 1'b0;
    long_hold_req = 1'b0;
    items_sent    = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_tick();
    drive_item(1'b0, 0, 0, 0, 0, 0, 0, 32'h0000_0000);
    drive_item(1'b0, 0, 0, 3, 0, 0, 2, 32'hFFFF_FFFF);
    repeat (7) send_tick();
    drive_item(1'b0, -2048, -2048, 2047, -2048, -2048, 2047, 32'h0000_0000);
    repeat (2) send_tick();
    drive_item(1'b0, 2047, 2047, -2048, 2047, 2047, -2048, 32'hA5A5_A5A5);
    repeat (2) send_tick();
    drive_item(1'b0, 0, 0, 2, 2, 4, 4, 32'h5A5A_5A5A);
    repeat (4) send_tick();
    drive_item(1'b0, 0, 5, 7, 5, 3, 5, 32'h1234_5678);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        release_input();
        wait_drained();
        program_setting(phase);
      end
      if (phase == 1) long_hold_req = 1'b1;
      if (phase == PHASES - 1) quiet = 1'b1;
      while (items_sent < (phase + 1) * PHASE_ITEMS) send_random_triangle();
    end

    release_input();
    wait_drained();
    if (tracker.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/tbr_pkg.sv
rtl/core/tbr_queue.sv
rtl/core/tbr_front.sv
rtl/core/tbr_back.sv
rtl/core/triangle_bbox_rasterizer_core.sv
sim/triangle_bbox_rasterizer_core_tb.sv
